// ===== src/gffrp_pkg.sv =====
// Shared types, constants and helpers for the first-fit grid placer.
// No dependencies; every other file of the block imports this package.
package gffrp_pkg;

  // Grid geometry and id width
  localparam int MAX_COLUMNS = 16;
  localparam int MAX_ROWS    = 16;
  localparam int ID_BITS     = 8;
  localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int COL_IW      = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int ROW_IW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  // Fixed field widths of the stream words
  localparam int CFG_W       = 5;
  localparam int OP_W        = 2;
  localparam int ITEM_ID_W   = 8;
  localparam int EXT_W       = 5;
  localparam int STATUS_W    = 3;
  localparam int POS_W       = 4;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 16;

  // Width that holds any extent, register value or position sum
  localparam int MAX_DIM     = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
  localparam int CNT_BITS    = $clog2(2 * MAX_DIM + 2);
  localparam int DIM_W       = (CNT_BITS > CFG_W) ? CNT_BITS : CFG_W;

  localparam logic [CFG_W-1:0] CFG_COLS_RESET = CFG_W'(16);
  localparam logic [CFG_W-1:0] CFG_ROWS_RESET = CFG_W'(16);

  // Configuration register indexes
  typedef enum logic {
    REG_GRID_COLUMNS = 1'b0,
    REG_GRID_ROWS    = 1'b1
  } cfg_reg_t;

  // Request codes
  typedef enum logic [OP_W-1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_PLACED  = 3'd0,
    ST_NO_ROOM = 3'd1,
    ST_INVALID = 3'd2,
    ST_REMOVED = 3'd3,
    ST_CLEARED = 3'd4
  } status_t;

  // One result word
  typedef struct packed {
    logic [POS_W-1:0] place_row;
    logic [POS_W-1:0] place_column;
    logic             was_rotated;
    status_t          status;
  } result_t;

  // Commands from the sequencer to the grid storage
  typedef struct packed {
    logic              clr_all;
    logic              wr_en;
    logic [ROW_IW-1:0] wr_row;
    logic [COL_IW-1:0] wr_col;
    logic [ID_BITS-1:0] wr_id;
    logic              rm_en;
    logic [ROW_IW-1:0] rm_row;
    logic [COL_IW-1:0] rm_col;
    logic [ROW_IW-1:0] rd_row;
    logic [COL_IW-1:0] rd_col;
  } grid_cmd_t;

  // Registered read of one cell
  typedef struct packed {
    logic               occ;
    logic [ID_BITS-1:0] owner;
  } grid_rd_t;

  // Flat owner memory address of a cell
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_IW-1:0] row,
                                                  input logic [COL_IW-1:0] col);
    int a;
    a = int'(row) * MAX_COLUMNS + int'(col);
    return ADDR_W'(a);
  endfunction

  // Register value saturated to the grid maximum
  function automatic logic [DIM_W-1:0] sat_dim(input logic [CFG_W-1:0] v,
                                               input int lim);
    logic [DIM_W-1:0] x;
    x = DIM_W'(v);
    return (x > DIM_W'(lim)) ? DIM_W'(lim) : x;
  endfunction

  // Rectangle of w by h can lie somewhere in a cols by rows grid
  function automatic logic fits(input logic [EXT_W-1:0] w, input logic [EXT_W-1:0] h,
                                input logic [DIM_W-1:0] cols,
                                input logic [DIM_W-1:0] rows);
    return (w != '0) && (h != '0) && (DIM_W'(w) <= cols) && (DIM_W'(h) <= rows);
  endfunction

endpackage

// ===== src/grid_first_fit_rect_placer_unit.sv =====
// Top level of the first-fit grid placer: stream ports, configuration
// registers and the output register. Depends on gffrp_pkg, gffrp_grid, gffrp_seq.
//
// Usage: a request word on in_* asks to add an item (id, width, height), to
// remove every cell of an id, or to clear the grid. Each request gives exactly
// one result word on out_*: status, rotation flag and top-left column and row.
// The cfg_* channel writes grid_columns (index 0) and grid_rows (index 1);
// write them only while no request is in flight. cfg_ready is always high.
// One request word is taken at a time; in_tready drops after accept.
// An add checks one row segment of the candidate rectangle per cycle over the
// tried positions, then writes its w*h cells. A remove sweeps all cells
// through the owner memory read port. Clear, invalid and oversized requests
// go from the decide step straight to the result.
// The result sits in an output register; the next request is accepted while
// it waits, and a further result holds in the sequencer until out_tready.
// Reset empties the grid at once and sets both registers to 16.
module grid_first_fit_rect_placer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: operation[1:0], item_id[9:2], item_width[14:10], item_height[19:15]
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [gffrp_pkg::IN_DATA_W-1:0]     in_tdata,
  // out_tdata: status[2:0], was_rotated[3], place_column[7:4], place_row[11:8]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [gffrp_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic                                cfg_index,
  input  logic [gffrp_pkg::CFG_W-1:0]         cfg_data
);
  import gffrp_pkg::*;

  logic [CFG_W-1:0]       cols_r, rows_r;
  logic                   out_valid_r;
  result_t                out_res_r;
  logic                   slot_free, res_push;
  result_t                res;
  grid_cmd_t              cmd;
  grid_rd_t               rd;
  logic [ROW_IW-1:0]      probe_row;
  logic [MAX_COLUMNS-1:0] probe_bits;

  // Configuration registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= CFG_COLS_RESET;
      rows_r <= CFG_ROWS_RESET;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_GRID_COLUMNS: cols_r <= cfg_data;
        REG_GRID_ROWS:    rows_r <= cfg_data;
        default: ;
      endcase
    end
  end

  gffrp_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .req_op     (in_tdata[1:0]),
    .req_id     (in_tdata[9:2]),
    .req_w      (in_tdata[14:10]),
    .req_h      (in_tdata[19:15]),
    .cfg_cols   (cols_r),
    .cfg_rows   (rows_r),
    .slot_free  (slot_free),
    .res_push   (res_push),
    .res        (res),
    .cmd        (cmd),
    .probe_row  (probe_row),
    .probe_bits (probe_bits),
    .rd         (rd)
  );

  gffrp_grid u_grid (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .probe_row  (probe_row),
    .probe_bits (probe_bits),
    .rd         (rd)
  );

  // Output register: load a result word, drop it once taken
  assign slot_free = !out_valid_r || out_tready;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (res_push) out_res_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DATA_W'(out_res_r);

endmodule

// ===== src/gffrp_grid.sv =====
// Grid storage: per-cell occupancy flags in flip-flops plus the owner id memory.
// Depends on gffrp_pkg.
module gffrp_grid (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gffrp_pkg::grid_cmd_t              cmd,
  input  logic [gffrp_pkg::ROW_IW-1:0]      probe_row,
  output logic [gffrp_pkg::MAX_COLUMNS-1:0] probe_bits,
  output gffrp_pkg::grid_rd_t               rd
);
  import gffrp_pkg::*;

  logic [MAX_COLUMNS-1:0] occ_r [MAX_ROWS];
  logic [ID_BITS-1:0]     owner_mem [CELLS];

  // Occupancy flags: cleared at reset and by a clear request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int r = 0; r < MAX_ROWS; r++) occ_r[r] <= '0;
    end else if (cmd.clr_all) begin
      for (int r = 0; r < MAX_ROWS; r++) occ_r[r] <= '0;
    end else begin
      if (cmd.wr_en) occ_r[cmd.wr_row][cmd.wr_col] <= 1'b1;
      if (cmd.rm_en) occ_r[cmd.rm_row][cmd.rm_col] <= 1'b0;
    end
  end

  // Owner memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr_en) owner_mem[cell_addr(cmd.wr_row, cmd.wr_col)] <= cmd.wr_id;
    rd.owner <= owner_mem[cell_addr(cmd.rd_row, cmd.rd_col)];
    rd.occ   <= occ_r[cmd.rd_row][cmd.rd_col];
  end

  // One row of occupancy for the rectangle check
  assign probe_bits = occ_r[probe_row];

endmodule

// ===== src/gffrp_seq.sv =====
// Request sequencer: scans positions with one row-segment check per cycle,
// fills the rectangle cell by cell and sweeps the grid for removals.
// Depends on gffrp_pkg; drives gffrp_grid.
module gffrp_seq (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  logic [gffrp_pkg::OP_W-1:0]        req_op,
  input  logic [gffrp_pkg::ITEM_ID_W-1:0]   req_id,
  input  logic [gffrp_pkg::EXT_W-1:0]       req_w,
  input  logic [gffrp_pkg::EXT_W-1:0]       req_h,
  input  logic [gffrp_pkg::CFG_W-1:0]       cfg_cols,
  input  logic [gffrp_pkg::CFG_W-1:0]       cfg_rows,
  input  logic                              slot_free,
  output logic                              res_push,
  output gffrp_pkg::result_t                res,
  output gffrp_pkg::grid_cmd_t              cmd,
  output logic [gffrp_pkg::ROW_IW-1:0]      probe_row,
  input  logic [gffrp_pkg::MAX_COLUMNS-1:0] probe_bits,
  input  gffrp_pkg::grid_rd_t               rd
);
  import gffrp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_SCAN, S_FILL, S_RM, S_RM_END, S_DONE
  } state_t;

  state_t             state_r, state_nxt;
  op_t                op_r, op_nxt;
  logic [ID_BITS-1:0] id_r, id_nxt;
  logic [EXT_W-1:0]   iw_r, iw_nxt, ih_r, ih_nxt;
  logic [EXT_W-1:0]   w_r, w_nxt, h_r, h_nxt;
  logic               rot_r, rot_nxt;
  logic [ROW_IW-1:0]  r_r, r_nxt, k_r, k_nxt;
  logic [COL_IW-1:0]  c_r, c_nxt, j_r, j_nxt;
  logic [ROW_IW-1:0]  rm_row_r, rm_row_nxt, pend_row_r, pend_row_nxt;
  logic [COL_IW-1:0]  rm_col_r, rm_col_nxt, pend_col_r, pend_col_nxt;
  logic               pend_r, pend_nxt;
  result_t            res_r, res_nxt;

  logic [DIM_W-1:0]       cols, rows;
  logic [MAX_COLUMNS:0]   ones;
  logic [MAX_COLUMNS-1:0] seg_mask;
  logic                   hit;

  assign cols = sat_dim(cfg_cols, MAX_COLUMNS);
  assign rows = sat_dim(cfg_rows, MAX_ROWS);

  // Row-segment check: covered columns of the probed row
  assign probe_row = r_r + k_r;
  assign ones      = ((MAX_COLUMNS + 1)'(1) << w_r) - (MAX_COLUMNS + 1)'(1);
  assign seg_mask  = MAX_COLUMNS'(ones << c_r);
  assign hit       = |(probe_bits & seg_mask);

  assign req_ready = (state_r == S_IDLE);
  assign res       = res_r;

  always_comb begin
    state_nxt    = state_r;
    op_nxt       = op_r;
    id_nxt       = id_r;
    iw_nxt       = iw_r;
    ih_nxt       = ih_r;
    w_nxt        = w_r;
    h_nxt        = h_r;
    rot_nxt      = rot_r;
    r_nxt        = r_r;
    c_nxt        = c_r;
    k_nxt        = k_r;
    j_nxt        = j_r;
    rm_row_nxt   = rm_row_r;
    rm_col_nxt   = rm_col_r;
    pend_nxt     = 1'b0;
    pend_row_nxt = pend_row_r;
    pend_col_nxt = pend_col_r;
    res_nxt      = res_r;
    res_push     = 1'b0;

    cmd         = '0;
    cmd.wr_row  = r_r + k_r;
    cmd.wr_col  = c_r + j_r;
    cmd.wr_id   = id_r;
    cmd.rd_row  = rm_row_r;
    cmd.rd_col  = rm_col_r;
    cmd.rm_row  = pend_row_r;
    cmd.rm_col  = pend_col_r;
    // Drop a cell of the swept id in the cycle after its read
    cmd.rm_en   = pend_r && rd.occ && (rd.owner == id_r);

    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          op_nxt    = op_t'(req_op);
          id_nxt    = ID_BITS'(req_id);
          iw_nxt    = req_w;
          ih_nxt    = req_h;
          state_nxt = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_nxt   = '{place_row: '0, place_column: '0, was_rotated: 1'b0,
                      status: ST_INVALID};
        state_nxt = S_DONE;
        r_nxt     = '0;
        c_nxt     = '0;
        k_nxt     = '0;
        j_nxt     = '0;
        case (op_r)
          OP_ADD: begin
            if (id_r != '0) begin
              if (fits(iw_r, ih_r, cols, rows)) begin
                w_nxt     = iw_r;
                h_nxt     = ih_r;
                rot_nxt   = 1'b0;
                state_nxt = S_SCAN;
              end else if (fits(ih_r, iw_r, cols, rows)) begin
                w_nxt     = ih_r;
                h_nxt     = iw_r;
                rot_nxt   = 1'b1;
                state_nxt = S_SCAN;
              end else begin
                res_nxt.status = ST_NO_ROOM;
              end
            end
          end
          OP_REMOVE: begin
            if (id_r != '0) begin
              rm_row_nxt = '0;
              rm_col_nxt = '0;
              state_nxt  = S_RM;
            end
          end
          OP_CLEAR: begin
            cmd.clr_all    = 1'b1;
            res_nxt.status = ST_CLEARED;
          end
          default: ;
        endcase
      end

      // One row of the candidate rectangle per cycle
      S_SCAN: begin
        if (hit) begin
          k_nxt = '0;
          if (DIM_W'(c_r) + DIM_W'(1) + DIM_W'(w_r) <= cols) begin
            c_nxt = c_r + 1'b1;
          end else if (DIM_W'(r_r) + DIM_W'(1) + DIM_W'(h_r) <= rows) begin
            r_nxt = r_r + 1'b1;
            c_nxt = '0;
          end else if (!rot_r && fits(h_r, w_r, cols, rows)) begin
            w_nxt   = h_r;
            h_nxt   = w_r;
            rot_nxt = 1'b1;
            r_nxt   = '0;
            c_nxt   = '0;
          end else begin
            res_nxt   = '{place_row: '0, place_column: '0, was_rotated: 1'b0,
                          status: ST_NO_ROOM};
            state_nxt = S_DONE;
          end
        end else if (DIM_W'(k_r) + DIM_W'(1) == DIM_W'(h_r)) begin
          k_nxt     = '0;
          j_nxt     = '0;
          state_nxt = S_FILL;
        end else begin
          k_nxt = k_r + 1'b1;
        end
      end

      // Write the id into one covered cell per cycle
      S_FILL: begin
        cmd.wr_en = 1'b1;
        if (DIM_W'(j_r) + DIM_W'(1) == DIM_W'(w_r)) begin
          j_nxt = '0;
          if (DIM_W'(k_r) + DIM_W'(1) == DIM_W'(h_r)) begin
            res_nxt   = '{place_row: POS_W'(r_r), place_column: POS_W'(c_r),
                          was_rotated: rot_r, status: ST_PLACED};
            state_nxt = S_DONE;
          end else begin
            k_nxt = k_r + 1'b1;
          end
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end

      // Sweep every cell, reading one owner per cycle
      S_RM: begin
        pend_nxt     = 1'b1;
        pend_row_nxt = rm_row_r;
        pend_col_nxt = rm_col_r;
        if (rm_col_r == COL_IW'(MAX_COLUMNS - 1)) begin
          rm_col_nxt = '0;
          if (rm_row_r == ROW_IW'(MAX_ROWS - 1)) state_nxt = S_RM_END;
          else rm_row_nxt = rm_row_r + 1'b1;
        end else begin
          rm_col_nxt = rm_col_r + 1'b1;
        end
      end

      S_RM_END: begin
        res_nxt   = '{place_row: '0, place_column: '0, was_rotated: 1'b0,
                      status: ST_REMOVED};
        state_nxt = S_DONE;
      end

      // Hand the result to the output register once it is free
      S_DONE: begin
        if (slot_free) begin
          res_push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    iw_r       <= iw_nxt;
    ih_r       <= ih_nxt;
    w_r        <= w_nxt;
    h_r        <= h_nxt;
    rot_r      <= rot_nxt;
    r_r        <= r_nxt;
    c_r        <= c_nxt;
    k_r        <= k_nxt;
    j_r        <= j_nxt;
    rm_row_r   <= rm_row_nxt;
    rm_col_r   <= rm_col_nxt;
    pend_row_r <= pend_row_nxt;
    pend_col_r <= pend_col_nxt;
    res_r      <= res_nxt;
  end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking bench for the first-fit grid placer: directed and random requests,
// grid-size changes, and a predictor that keeps its own copy of the cell owners.
// Depends on gffrp_pkg and grid_first_fit_rect_placer_unit.
`timescale 1ns / 1ps

module tb;
  import gffrp_pkg::*;

  localparam int QUIET_LIMIT = 40000;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_index  = 1'b0;
  logic [CFG_W-1:0]      cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_ready;

  grid_first_fit_rect_placer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    // in_tdata: operation, item_id, item_width, item_height
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    // out_tdata: status, was_rotated, place_column, place_row
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial forever #5 clk = ~clk;

  // Predictor state: cell owners, grid registers, expected result words
  logic [ID_BITS-1:0] owner_map [CELLS];
  logic [CFG_W-1:0]   cols_cfg = CFG_COLS_RESET;
  logic [CFG_W-1:0]   rows_cfg = CFG_ROWS_RESET;
  result_t            pending_results [$];
  int                 mismatch_count = 0;
  int                 quiet_cycles   = 0;
  bit                 gaps_on        = 1'b1;

  // Clamp a register value to the grid maximum
  function automatic int span_in_use(logic [CFG_W-1:0] v, int lim);
    return (int'(v) > lim) ? lim : int'(v);
  endfunction

  function automatic bit area_empty(int c, int r, int w, int h);
    for (int rr = r; rr < r + h; rr++)
      for (int cc = c; cc < c + w; cc++)
        if (owner_map[rr * MAX_COLUMNS + cc] != '0) return 1'b0;
    return 1'b1;
  endfunction

  // Row-major search for the first empty w by h area inside the grid in use
  function automatic bit first_fit(int w, int h, output int pc, output int pr);
    int cols, rows;
    cols = span_in_use(cols_cfg, MAX_COLUMNS);
    rows = span_in_use(rows_cfg, MAX_ROWS);
    pc = 0;
    pr = 0;
    if (w == 0 || h == 0 || w > cols || h > rows) return 1'b0;
    for (int r = 0; r + h <= rows; r++)
      for (int c = 0; c + w <= cols; c++)
        if (area_empty(c, r, w, h)) begin
          pc = c;
          pr = r;
          return 1'b1;
        end
    return 1'b0;
  endfunction

  function automatic void paint_area(int c, int r, int w, int h, logic [ID_BITS-1:0] id);
    for (int rr = r; rr < r + h; rr++)
      for (int cc = c; cc < c + w; cc++)
        owner_map[rr * MAX_COLUMNS + cc] = id;
  endfunction

  // Apply one request to the owner map and return the result word it gives
  function automatic result_t place_predict(op_t op, logic [ITEM_ID_W-1:0] id,
                                            logic [EXT_W-1:0] w, logic [EXT_W-1:0] h);
    result_t res;
    int      pc, pr;
    logic [ID_BITS-1:0] key;
    res = '0;
    res.status = ST_INVALID;
    key = id[ID_BITS-1:0];
    case (op)
      OP_ADD: begin
        if (key != '0) begin
          if (first_fit(w, h, pc, pr)) begin
            paint_area(pc, pr, w, h, key);
            res.status       = ST_PLACED;
            res.place_column = pc[POS_W-1:0];
            res.place_row    = pr[POS_W-1:0];
          end else if (first_fit(h, w, pc, pr)) begin
            paint_area(pc, pr, h, w, key);
            res.status       = ST_PLACED;
            res.was_rotated  = 1'b1;
            res.place_column = pc[POS_W-1:0];
            res.place_row    = pr[POS_W-1:0];
          end else begin
            res.status = ST_NO_ROOM;
          end
        end
      end
      OP_REMOVE: begin
        if (key != '0) begin
          foreach (owner_map[i])
            if (owner_map[i] == key) owner_map[i] = '0;
          res.status = ST_REMOVED;
        end
      end
      OP_CLEAR: begin
        foreach (owner_map[i]) owner_map[i] = '0;
        res.status = ST_CLEARED;
      end
      default: ;
    endcase
    return res;
  endfunction

  // Send one request word, then record the result it must produce
  task automatic send_request(op_t op, logic [ITEM_ID_W-1:0] id,
                              logic [EXT_W-1:0] w, logic [EXT_W-1:0] h);
    int gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 15);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_DATA_W - 20){1'b0}}, h, w, id, op};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(place_predict(op, id, w, h));
  endtask

  // Drop valid and wait until every pending result has arrived
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Hold cfg_valid high; the caller lowers it after the last word
  task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_GRID_COLUMNS) cols_cfg = val;
    else rows_cfg = val;
  endtask

  task automatic set_grid(logic [CFG_W-1:0] cols, logic [CFG_W-1:0] rows);
    settle();
    write_reg(REG_GRID_COLUMNS, cols);
    write_reg(REG_GRID_ROWS, rows);
    cfg_valid <= 1'b0;
  endtask

  // Mostly small extents, some up to the full grid, a few out of range
  function automatic logic [EXT_W-1:0] random_extent();
    int k;
    k = $urandom_range(0, 9);
    if (k < 7) return EXT_W'($urandom_range(1, 4));
    if (k < 9) return EXT_W'($urandom_range(1, 16));
    return EXT_W'($urandom_range(0, 31));
  endfunction

  // Small id pool so removes and duplicates hit live items
  function automatic logic [ITEM_ID_W-1:0] random_id();
    if ($urandom_range(0, 7) == 0) return ITEM_ID_W'($urandom_range(1, 255));
    return ITEM_ID_W'($urandom_range(1, 24));
  endfunction

  task automatic send_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 58)
      send_request(OP_ADD, random_id(), random_extent(), random_extent());
    else if (pick < 78)
      send_request(OP_REMOVE, random_id(), random_extent(), random_extent());
    else if (pick < 83)
      send_request(OP_CLEAR, ITEM_ID_W'($urandom_range(0, 255)),
                   EXT_W'($urandom_range(0, 31)), EXT_W'($urandom_range(0, 31)));
    else if (pick < 88)
      send_request(OP_NONE, ITEM_ID_W'($urandom_range(0, 255)),
                   EXT_W'($urandom_range(0, 31)), EXT_W'($urandom_range(0, 31)));
    else if (pick < 94)
      send_request(($urandom_range(0, 1) == 0) ? OP_ADD : OP_REMOVE, '0,
                   random_extent(), random_extent());
    else
      send_request(OP_ADD, ITEM_ID_W'($urandom_range(0, 255)),
                   EXT_W'($urandom_range(0, 31)), EXT_W'($urandom_range(0, 31)));
  endtask

  // Extremes of every field, each operation and each special case
  task automatic test_directed();
    send_request(OP_ADD, 8'd1, 5'd16, 5'd16);     // fills the whole grid
    send_request(OP_ADD, 8'd2, 5'd1, 5'd1);       // full grid: no room
    send_request(OP_CLEAR, 8'd255, 5'd31, 5'd31);
    send_request(OP_ADD, 8'd0, 5'd1, 5'd1);       // id zero is refused
    send_request(OP_REMOVE, 8'd0, 5'd1, 5'd1);
    send_request(OP_NONE, 8'd170, 5'd21, 5'd10);  // unknown operation
    send_request(OP_NONE, 8'd85, 5'd10, 5'd21);
    send_request(OP_ADD, 8'd3, 5'd0, 5'd4);       // zero extents never fit
    send_request(OP_ADD, 8'd3, 5'd4, 5'd0);
    send_request(OP_ADD, 8'd4, 5'd17, 5'd1);      // larger than the grid
    send_request(OP_ADD, 8'd4, 5'd31, 5'd31);
    send_request(OP_ADD, 8'd255, 5'd16, 5'd1);    // top row
    send_request(OP_ADD, 8'd200, 5'd1, 5'd16);    // fits only after swapping
    send_request(OP_ADD, 8'd200, 5'd2, 5'd2);     // duplicate id accepted
    send_request(OP_REMOVE, 8'd77, 5'd1, 5'd1);   // absent id
    send_request(OP_REMOVE, 8'd200, 5'd1, 5'd1);  // drops both copies
    send_request(OP_ADD, 8'd5, 5'd3, 5'd2);
    send_request(OP_REMOVE, 8'd255, 5'd1, 5'd1);
    send_request(OP_ADD, 8'd6, 5'd16, 5'd1);
    send_request(OP_CLEAR, 8'd0, 5'd0, 5'd0);
  endtask

  // Cells outside a shrunk grid keep their owners; remove still reaches them
  task automatic test_resize_keeps_cells();
    set_grid(5'd16, 5'd16);
    send_request(OP_ADD, 8'd40, 5'd16, 5'd1);
    send_request(OP_ADD, 8'd41, 5'd1, 5'd16);
    set_grid(5'd16, 5'd2);
    send_request(OP_ADD, 8'd42, 5'd1, 5'd1);
    set_grid(5'd16, 5'd3);
    send_request(OP_ADD, 8'd42, 5'd1, 5'd1);
    set_grid(5'd4, 5'd16);
    send_request(OP_REMOVE, 8'd40, 5'd1, 5'd1);
    send_request(OP_ADD, 8'd43, 5'd4, 5'd1);
    set_grid(5'd16, 5'd16);
    send_request(OP_ADD, 8'd44, 5'd12, 5'd1);
    send_request(OP_CLEAR, 8'd0, 5'd1, 5'd1);
  endtask

  // Zero, one, full and saturating register values
  task automatic test_config_extremes();
    logic [CFG_W-1:0] col_set [9] = '{5'd0, 5'd16, 5'd0, 5'd1, 5'd31, 5'd17, 5'd2, 5'd1, 5'd16};
    logic [CFG_W-1:0] row_set [9] = '{5'd16, 5'd0, 5'd0, 5'd1, 5'd31, 5'd2, 5'd17, 5'd16, 5'd1};
    for (int k = 0; k < 9; k++) begin
      set_grid(col_set[k], row_set[k]);
      send_request(OP_CLEAR, 8'd0, 5'd0, 5'd0);
      repeat (8) send_random();
    end
  endtask

  // Long random traffic over several grid sizes; the last phase runs without gaps
  task automatic test_random_traffic();
    for (int phase = 0; phase < 6; phase++) begin
      if (phase == 5) set_grid(5'd16, 5'd16);
      else if ($urandom_range(0, 1) == 0) set_grid(5'd16, 5'd16);
      else set_grid(CFG_W'($urandom_range(1, 16)), CFG_W'($urandom_range(1, 16)));
      if (phase == 5) gaps_on = 1'b0;
      repeat (80) send_random();
    end
  endtask

  // Receiver: random stall bursts while gaps are on
  initial begin
    forever begin
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  function automatic void compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Check each result word against the oldest expectation
  always @(posedge clk) begin : result_check
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = result_t'(out_tdata[11:0]);
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word: expected none, actual %h", $time, out_tdata);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("was_rotated", want.was_rotated, got.was_rotated);
        compare_field("place_column", want.place_column, got.place_column);
        compare_field("place_row", want.place_row, got.place_row);
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    foreach (owner_map[i]) owner_map[i] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_resize_keeps_cells();
    test_config_extremes();
    test_random_traffic();
    settle();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
src/gffrp_pkg.sv
src/gffrp_grid.sv
src/gffrp_seq.sv
src/grid_first_fit_rect_placer_unit.sv
tb/sv/tb.sv
